// ----- design/shl2_pkg.sv -----
// Package: shared constants, types and rounding helpers for the SH L2 irradiance unit.
`timescale 1ns / 1ps
package shl2_pkg;

  localparam int COEFF_WIDTH  = 24;
  localparam int NORMAL_WIDTH = 16;
  localparam int NUM_COEF     = 9;
  localparam int IDX_W        = 4;
  localparam int NRM_W        = 24;  // normal in Q.22
  localparam int PROD_W       = 2 * NRM_W;
  localparam int MONO_W       = 36;  // monomials in Q.30
  localparam int BASIS_W      = 21;  // basis values in Q.16
  localparam int FACTOR_W     = 19;  // signed width of band factors

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // basis constants, Q.16
  localparam logic signed [17:0] K_Y0  = 18'sd18487;
  localparam logic signed [17:0] K_Y1  = 18'sd32021;
  localparam logic signed [17:0] K_Y2A = 18'sd71602;
  localparam logic signed [17:0] K_Y2B = 18'sd20670;
  localparam logic signed [17:0] K_Y2C = 18'sd35801;

  // per-stage advance enables
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
    logic en6;
  } adv_t;

  typedef struct packed {
    logic signed [NRM_W-1:0]  x;
    logic signed [NRM_W-1:0]  y;
    logic signed [NRM_W-1:0]  z;
    logic signed [MONO_W-1:0] xy;
    logic signed [MONO_W-1:0] yz;
    logic signed [MONO_W-1:0] xz;
    logic signed [MONO_W-1:0] m6;
    logic signed [MONO_W-1:0] m8;
  } mono_t;

  typedef logic [NUM_COEF-1:0][BASIS_W-1:0] basis_t;

  // Lambertian band factor, Q.16: pi, 2pi/3, pi/4
  function automatic logic signed [FACTOR_W-1:0] band_factor(input logic [IDX_W-1:0] idx);
    logic signed [FACTOR_W-1:0] f;
    if (idx == '0) begin
      f = 19'sd205887;
    end else if (idx < 4'd4) begin
      f = 19'sd137258;
    end else begin
      f = 19'sd51472;
    end
    return f;
  endfunction

  // round half up, then floor shift
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] p,
                                                input int unsigned s);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

endpackage

// ----- design/shl2_in_if.sv -----
// Interface: request channel of the SH L2 irradiance unit.
`timescale 1ns / 1ps
interface shl2_in_if #(
  parameter int CW = shl2_pkg::COEFF_WIDTH,
  parameter int NW = shl2_pkg::NORMAL_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [shl2_pkg::IDX_W-1:0]    coeff_index;
  logic signed [CW-1:0]          coeff_red;
  logic signed [CW-1:0]          coeff_green;
  logic signed [CW-1:0]          coeff_blue;
  logic signed [NW-1:0]          normal_x;
  logic signed [NW-1:0]          normal_y;
  logic signed [NW-1:0]          normal_z;

  modport source (
    output valid, operation, coeff_index, coeff_red, coeff_green, coeff_blue,
           normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, operation, coeff_index, coeff_red, coeff_green, coeff_blue,
           normal_x, normal_y, normal_z,
    output ready
  );
endinterface

// ----- design/shl2_out_if.sv -----
// Interface: result channel of the SH L2 irradiance unit.
`timescale 1ns / 1ps
interface shl2_out_if #(
  parameter int CW = shl2_pkg::COEFF_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] irradiance_red;
  logic signed [CW-1:0] irradiance_green;
  logic signed [CW-1:0] irradiance_blue;
  logic                 saturated;

  modport source (
    output valid, irradiance_red, irradiance_green, irradiance_blue, saturated,
    input  ready
  );
  modport sink (
    input  valid, irradiance_red, irradiance_green, irradiance_blue, saturated,
    output ready
  );
endinterface

// ----- design/shl2_mono.sv -----
// Monomial stages: component products, then rounded Q.30 monomials.
`timescale 1ns / 1ps
module shl2_mono (
  input  logic                                 clk_i,
  input  shl2_pkg::adv_t                       adv_i,
  input  logic signed [shl2_pkg::NRM_W-1:0]    x_i,
  input  logic signed [shl2_pkg::NRM_W-1:0]    y_i,
  input  logic signed [shl2_pkg::NRM_W-1:0]    z_i,
  output shl2_pkg::mono_t                      mono_o
);
  localparam int PW = shl2_pkg::PROD_W;
  localparam int MW = shl2_pkg::MONO_W;

  logic signed [PW-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pyz_q, pxz_q;
  logic signed [shl2_pkg::NRM_W-1:0] x2_q, y2_q, z2_q;
  shl2_pkg::mono_t mono_d, mono_q;

  // stage 2: raw products
  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      pxx_q <= x_i * x_i;
      pyy_q <= y_i * y_i;
      pzz_q <= z_i * z_i;
      pxy_q <= x_i * y_i;
      pyz_q <= y_i * z_i;
      pxz_q <= x_i * z_i;
      x2_q  <= x_i;
      y2_q  <= y_i;
      z2_q  <= z_i;
    end
  end

  always_comb begin
    logic signed [MW-1:0] xx, yy, zz;
    xx = MW'(shl2_pkg::rnd_sh(64'(pxx_q), 14));
    yy = MW'(shl2_pkg::rnd_sh(64'(pyy_q), 14));
    zz = MW'(shl2_pkg::rnd_sh(64'(pzz_q), 14));
    mono_d.x  = x2_q;
    mono_d.y  = y2_q;
    mono_d.z  = z2_q;
    mono_d.xy = MW'(shl2_pkg::rnd_sh(64'(pxy_q), 14));
    mono_d.yz = MW'(shl2_pkg::rnd_sh(64'(pyz_q), 14));
    mono_d.xz = MW'(shl2_pkg::rnd_sh(64'(pxz_q), 14));
    mono_d.m6 = (zz <<< 1) + zz - (MW'(1) <<< 30);
    mono_d.m8 = xx - yy;
  end

  // stage 3: monomials
  always_ff @(posedge clk_i) begin
    if (adv_i.en3) begin
      mono_q <= mono_d;
    end
  end

  assign mono_o = mono_q;
endmodule

// ----- design/shl2_basis.sv -----
// Basis stage: nine real L2 SH basis values in Q.16.
`timescale 1ns / 1ps
module shl2_basis (
  input  logic             clk_i,
  input  shl2_pkg::adv_t   adv_i,
  input  shl2_pkg::mono_t  mono_i,
  output shl2_pkg::basis_t basis_o
);
  localparam int BW = shl2_pkg::BASIS_W;

  shl2_pkg::basis_t basis_d, basis_q;

  always_comb begin
    logic signed [shl2_pkg::NRM_W+17:0]  p1, p2, p3;
    logic signed [shl2_pkg::MONO_W+17:0] p4, p5, p6, p7, p8;
    p1 = shl2_pkg::K_Y1 * mono_i.y;
    p2 = shl2_pkg::K_Y1 * mono_i.z;
    p3 = shl2_pkg::K_Y1 * mono_i.x;
    p4 = shl2_pkg::K_Y2A * mono_i.xy;
    p5 = shl2_pkg::K_Y2A * mono_i.yz;
    p6 = shl2_pkg::K_Y2B * mono_i.m6;
    p7 = shl2_pkg::K_Y2A * mono_i.xz;
    p8 = shl2_pkg::K_Y2C * mono_i.m8;
    basis_d[0] = BW'(shl2_pkg::K_Y0);
    // linear terms: component Q.22 times constant, scaled to Q.16
    basis_d[1] = BW'(shl2_pkg::rnd_sh(64'(p1), 22));
    basis_d[2] = BW'(shl2_pkg::rnd_sh(64'(p2), 22));
    basis_d[3] = BW'(shl2_pkg::rnd_sh(64'(p3), 22));
    basis_d[4] = BW'(shl2_pkg::rnd_sh(64'(p4), 30));
    basis_d[5] = BW'(shl2_pkg::rnd_sh(64'(p5), 30));
    basis_d[6] = BW'(shl2_pkg::rnd_sh(64'(p6), 30));
    basis_d[7] = BW'(shl2_pkg::rnd_sh(64'(p7), 30));
    basis_d[8] = BW'(shl2_pkg::rnd_sh(64'(p8), 30));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en4) begin
      basis_q <= basis_d;
    end
  end

  assign basis_o = basis_q;
endmodule

// ----- design/shl2_dot.sv -----
// Dot stages: basis times stored coefficients, then sum, round, clamp, saturate.
`timescale 1ns / 1ps
module shl2_dot #(
  parameter int CW = shl2_pkg::COEFF_WIDTH
) (
  input  logic                                          clk_i,
  input  shl2_pkg::adv_t                                adv_i,
  input  shl2_pkg::basis_t                              basis_i,
  input  logic [shl2_pkg::NUM_COEF-1:0][2:0][CW-1:0]    store_i,
  input  logic                                          clamp_i,
  output logic signed [CW-1:0]                          red_o,
  output logic signed [CW-1:0]                          green_o,
  output logic signed [CW-1:0]                          blue_o,
  output logic                                          sat_o
);
  localparam int NC = shl2_pkg::NUM_COEF;
  localparam int MW = CW + shl2_pkg::BASIS_W;
  localparam int SW = MW + 4;
  localparam logic signed [SW:0] HI = (SW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW:0] LO = -HI - (SW+1)'(1);

  logic signed [MW-1:0] prod_q [3][NC];
  logic signed [CW-1:0] chan_d [3];
  logic signed [CW-1:0] chan_q [3];
  logic                 sat_d, sat_q;

  // stage 5: 27 products
  always_ff @(posedge clk_i) begin
    if (adv_i.en5) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < NC; k++) begin
          prod_q[c][k] <= $signed(store_i[k][c]) * $signed(basis_i[k]);
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW:0]   e;
    sat_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int k = 0; k < NC; k++) begin
        acc = acc + SW'(prod_q[c][k]);
      end
      e = ((SW+1)'(acc) + (SW+1)'(32768)) >>> 16;
      if (clamp_i && e < 0) begin
        e = '0;
      end
      if (e > HI) begin
        chan_d[c] = CW'(HI);
        sat_d     = 1'b1;
      end else if (e < LO) begin
        chan_d[c] = CW'(LO);
        sat_d     = 1'b1;
      end else begin
        chan_d[c] = CW'(e);
      end
    end
  end

  // stage 6: result word
  always_ff @(posedge clk_i) begin
    if (adv_i.en6) begin
      chan_q <= chan_d;
      sat_q  <= sat_d;
    end
  end

  assign red_o   = chan_q[0];
  assign green_o = chan_q[1];
  assign blue_o  = chan_q[2];
  assign sat_o   = sat_q;
endmodule

// ----- design/sh_l2_irradiance_evaluate_unit.sv -----
// Top level: SH L2 diffuse irradiance unit with coefficient store and six-stage pipeline.
`timescale 1ns / 1ps
// A load word (operation 0) writes one RGB radiance coefficient, index 0..8 in band
// order, pre-scaled by its band's Lambertian factor and saturated; an index above 8 is
// dropped. Loads return nothing. An evaluate word (operation 1) takes a Q1.14 normal and
// returns one result word: the RGB irradiance in Q7.16, clamped at zero when
// clamp_negative is set, saturated, with a flag on saturation. One word is accepted per
// cycle unless the pipe stalls. There are six register stages (input, component products,
// monomials, basis, 27 coefficient products, sum and saturate); the first loads at the
// accepting edge. Each stage stalls only when it holds a word and the one after it
// stalls, so bubbles collapse and input flows while a result waits, until the pipe fills.
// The store is 9 registers cleared at reset; a load travels to stage 4 and is written as
// it leaves it, the same edge at which an evaluate would read the store into stage 5, so
// every evaluate sees exactly the loads that arrived before it. clamp_negative resets to
// 1; the user must see that it is written only while idle; the unit does not enforce that.
module sh_l2_irradiance_evaluate_unit #(
  parameter int COEFF_WIDTH  = shl2_pkg::COEFF_WIDTH,
  parameter int NORMAL_WIDTH = shl2_pkg::NORMAL_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      clamp_negative_we_i,
  input  logic      clamp_negative_i,
  shl2_in_if.sink   req_i,
  shl2_out_if.source rsp_o
);
  localparam int CW  = COEFF_WIDTH;
  localparam int NC  = shl2_pkg::NUM_COEF;
  localparam int NRW = shl2_pkg::NRM_W;
  localparam int UP  = NRW - NORMAL_WIDTH;      // shift to Q.22
  localparam int LPW = CW + shl2_pkg::FACTOR_W; // load product width
  localparam logic signed [LPW:0] HI = (LPW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [LPW:0] LO = -HI - (LPW+1)'(1);

  // pipeline control
  shl2_pkg::adv_t adv;
  logic en1;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  shl2_pkg::op_e op1_q, op2_q, op3_q, op4_q;

  // stage 1 payload
  logic [shl2_pkg::IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [CW-1:0]       coef1_q [3];
  logic signed [NRW-1:0]      x1_q, y1_q, z1_q;

  // load path
  logic signed [LPW-1:0] lp2_q [3];
  logic signed [CW-1:0]  ld_d [3];
  logic signed [CW-1:0]  ld3_q [3];
  logic signed [CW-1:0]  ld4_q [3];
  logic                  store_we;

  logic [NC-1:0][2:0][CW-1:0] store_q;
  logic                       clamp_q;

  shl2_pkg::mono_t  mono;
  shl2_pkg::basis_t basis;

  // stall chain: a stage advances when empty or when the next one advances
  assign adv.en6 = !v6_q || rsp_o.ready;
  assign adv.en5 = !v5_q || adv.en6;
  assign adv.en4 = !v4_q || adv.en5;
  assign adv.en3 = !v3_q || adv.en4;
  assign adv.en2 = !v2_q || adv.en3;
  assign en1     = !v1_q || adv.en2;
  assign req_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      op1_q <= shl2_pkg::OP_LOAD;
      op2_q <= shl2_pkg::OP_LOAD;
      op3_q <= shl2_pkg::OP_LOAD;
      op4_q <= shl2_pkg::OP_LOAD;
    end else begin
      if (en1) begin
        v1_q  <= req_i.valid;
        op1_q <= shl2_pkg::op_e'(req_i.operation);
      end
      if (adv.en2) begin
        v2_q  <= v1_q;
        op2_q <= op1_q;
      end
      if (adv.en3) begin
        v3_q  <= v2_q;
        op3_q <= op2_q;
      end
      if (adv.en4) begin
        v4_q  <= v3_q;
        op4_q <= op3_q;
      end
      // loads retire at stage 4; only evaluates go on
      if (adv.en5) v5_q <= v4_q && (op4_q == shl2_pkg::OP_EVAL);
      if (adv.en6) v6_q <= v5_q;
    end
  end

  // stage 1 payload, normal widened to Q.22
  always_ff @(posedge clk_i) begin
    if (en1) begin
      idx1_q     <= req_i.coeff_index;
      coef1_q[0] <= req_i.coeff_red;
      coef1_q[1] <= req_i.coeff_green;
      coef1_q[2] <= req_i.coeff_blue;
      x1_q       <= NRW'(req_i.normal_x) <<< UP;
      y1_q       <= NRW'(req_i.normal_y) <<< UP;
      z1_q       <= NRW'(req_i.normal_z) <<< UP;
    end
  end

  // stage 2 load products
  always_ff @(posedge clk_i) begin
    if (adv.en2) begin
      idx2_q <= idx1_q;
      for (int c = 0; c < 3; c++) begin
        lp2_q[c] <= coef1_q[c] * shl2_pkg::band_factor(idx1_q);
      end
    end
  end

  // round to Q.16 then saturate
  always_comb begin
    logic signed [LPW:0] r;
    for (int c = 0; c < 3; c++) begin
      r = ((LPW+1)'(lp2_q[c]) + (LPW+1)'(32768)) >>> 16;
      if (r > HI) begin
        ld_d[c] = CW'(HI);
      end else if (r < LO) begin
        ld_d[c] = CW'(LO);
      end else begin
        ld_d[c] = CW'(r);
      end
    end
  end

  // stages 3 and 4: scaled load word waits for its store slot
  always_ff @(posedge clk_i) begin
    if (adv.en3) begin
      idx3_q <= idx2_q;
      ld3_q  <= ld_d;
    end
    if (adv.en4) begin
      idx4_q <= idx3_q;
      ld4_q  <= ld3_q;
    end
  end

  assign store_we = v4_q && (op4_q == shl2_pkg::OP_LOAD) && adv.en5 &&
                    (idx4_q < shl2_pkg::IDX_W'(NC));

  // coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (store_we) begin
      for (int c = 0; c < 3; c++) begin
        store_q[idx4_q][c] <= ld4_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b1;
    end else if (clamp_negative_we_i) begin
      clamp_q <= clamp_negative_i;
    end
  end

  shl2_mono u_mono (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .x_i    (x1_q),
    .y_i    (y1_q),
    .z_i    (z1_q),
    .mono_o (mono)
  );

  shl2_basis u_basis (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .mono_i  (mono),
    .basis_o (basis)
  );

  shl2_dot #(.CW(CW)) u_dot (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .basis_i (basis),
    .store_i (store_q),
    .clamp_i (clamp_q),
    .red_o   (rsp_o.irradiance_red),
    .green_o (rsp_o.irradiance_green),
    .blue_o  (rsp_o.irradiance_blue),
    .sat_o   (rsp_o.saturated)
  );

  assign rsp_o.valid = v6_q;

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !rsp_o.ready && v5_q && v4_q && v3_q && v2_q && v1_q) |-> !req_i.ready)
    else $error("accepted a word into a full stalled pipe");
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !v4_q && !v5_q && !v6_q) |-> req_i.ready)
    else $error("empty pipe refused a word");
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv.en6 && v5_q) |=> v6_q)
    else $error("evaluate lost between stage 5 and output");
  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv.en5 && v4_q && op4_q == shl2_pkg::OP_LOAD) |=> !v5_q)
    else $error("load word passed beyond stage 4");
`endif
endmodule
